@@ rtl/markov_sequence_scorer_top_assert.svh @@
// Assertion macros for the Markov sequence scorer.
// Included by the top level; the SYNTH macro selects the empty bodies.
`ifndef MARKOV_SEQUENCE_SCORER_TOP_ASSERT_SVH
`define MARKOV_SEQUENCE_SCORER_TOP_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, checked out of reset
`define MSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("msc assertion failed");

// Next-cycle implication, checked out of reset
`define MSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("msc assertion failed");

`else

`define MSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define MSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/msc_pkg.sv @@
// Shared types and constants of the Markov sequence scorer.
// No dependencies; used by the interfaces, the result FIFO and the top level.
package msc_pkg;

    // Item field widths
    localparam int OPCODE_W = 2;
    localparam int LEVEL_W  = 3;
    localparam int LEVELS   = 1 << LEVEL_W;
    localparam int INDEX_W  = 12;
    localparam int VALUE_W  = 32;
    localparam int SYM_W    = 2;
    localparam int SCORE_W  = 48;

    // Linear product: Q1.31 times Q1.31, renormalised by the fraction width
    localparam int PROD_W    = 2 * VALUE_W;
    localparam int FRAC_BITS = 31;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_MODEL_ORDER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOG_MODE    = 1'd1;

    localparam logic [LEVEL_W-1:0] ORDER_RESET    = 3'd2;
    localparam logic               LOG_MODE_RESET = 1'b1;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_LOAD_COND  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_LOAD_JOINT = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_SYMBOL     = 2'd2;

    // Saturation limits of the log sum
    localparam logic [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
    localparam logic [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

    // Result FIFO
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // What a symbol does once its table entry is back
    typedef enum logic [1:0] {
        KIND_SHORT = 2'd0,
        KIND_JOINT = 2'd1,
        KIND_COND  = 2'd2
    } t_kind;

    typedef struct packed {
        logic  valid;
        t_kind kind;
        logic  last;
    } t_s1;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic                      score_saturated;
    } t_result;

    typedef struct packed {
        logic                 not_empty;
        logic                 full;
        logic [OUT_CNT_W-1:0] count;
    } t_fifo_stat;

endpackage

@@ rtl/msc_ifs.sv @@
// Valid/ready channels of the Markov sequence scorer: request and result.
// Depends on msc_pkg for the field widths.
interface msc_req_if import msc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [LEVEL_W-1:0]  table_level;
    logic [INDEX_W-1:0]  table_index;
    logic [VALUE_W-1:0]  table_value;
    logic [SYM_W-1:0]    symbol;
    logic                last_symbol;

    modport source (
        output valid, opcode, table_level, table_index, table_value, symbol, last_symbol,
        input  ready
    );
    modport sink (
        input  valid, opcode, table_level, table_index, table_value, symbol, last_symbol,
        output ready
    );
endinterface

interface msc_rsp_if import msc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [SCORE_W-1:0] score;
    logic                      score_saturated;

    modport source (output valid, score, score_saturated, input ready);
    modport sink (input valid, score, score_saturated, output ready);
endinterface

@@ rtl/msc_out_fifo.sv @@
// Result FIFO of the Markov sequence scorer: small register queue of result words.
// Depends on msc_pkg for the result word and status types.
module msc_out_fifo
    import msc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_result    i_push_data,
    input  logic       i_pop,
    output t_result    o_head,
    output t_fifo_stat o_stat
);

    t_result              r_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] r_wr_ptr;
    logic [OUT_PTR_W-1:0] r_rd_ptr;
    logic [OUT_CNT_W-1:0] r_cnt;

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Hold pushed words
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_head           = r_mem[r_rd_ptr];
    assign o_stat.not_empty = (r_cnt != '0);
    assign o_stat.full      = (r_cnt == OUT_CNT_W'(OUT_DEPTH));
    assign o_stat.count     = r_cnt;

endmodule

@@ rtl/markov_sequence_scorer_top.sv @@
// Markov sequence scorer: k-th order chain score over a symbol stream.
// A last symbol's result passes the stage 1 and stage 2 registers into the result FIFO.
// Throughput: one item per cycle; the linear product loop closes through one
// 32x32 multiplier whose operand is taken from the clamped product register.
// Input stalls only when the 4-word result FIFO plus results in flight are full.
// Reset: sequence state cleared, model_order 2, log mode on; tables undefined until loaded.
`include "markov_sequence_scorer_top_assert.svh"

module markov_sequence_scorer_top
    import msc_pkg::*;
#(
    parameter int MAX_ORDER   = 5,
    parameter int SYMBOL_BITS = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    msc_req_if.sink               i_req,
    msc_rsp_if.source             o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int WB          = SYMBOL_BITS * (MAX_ORDER + 1);
    localparam int JA          = WB + 1;
    localparam int SEEN_W      = $clog2(MAX_ORDER + 2);
    localparam int COND_DEPTH  = 1 << WB;
    localparam int JOINT_DEPTH = 1 << JA;
    localparam int EXT_W       = SCORE_W - VALUE_W;

    // Word mask of a level: (level + 1) symbols
    function automatic logic [WB-1:0] lvl_mask(input int lvl);
        int bits;
        bits = SYMBOL_BITS * (lvl + 1);
        if (bits >= WB) begin
            return '1;
        end
        return WB'((64'd1 << bits) - 64'd1);
    endfunction

    // Base of a level in the packed joint table
    function automatic logic [JA-1:0] lvl_base(input int lvl);
        logic [JA-1:0] sum;
        sum = '0;
        for (int j = 0; j < lvl; j++) begin
            sum = sum + JA'(64'd1 << (SYMBOL_BITS * (j + 1)));
        end
        return sum;
    endfunction

    // Clamp a renormalised linear product to 32 bits
    function automatic logic [VALUE_W-1:0] prod_clamp(input logic [PROD_W-1:0] p);
        return p[PROD_W-1] ? {VALUE_W{1'b1}} : p[FRAC_BITS +: VALUE_W];
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [LEVEL_W-1:0] r_order;
    logic               r_log_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order    <= ORDER_RESET;
            r_log_mode <= LOG_MODE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MODEL_ORDER: r_order    <= i_cfg_data;
                REG_LOG_MODE:    r_log_mode <= i_cfg_data[0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Per-level constant tables
    // ------------------------------------------------------------------
    logic [WB-1:0] w_lvl_mask [LEVELS];
    logic [JA-1:0] w_lvl_base [LEVELS];

    for (genvar g = 0; g < LEVELS; g++) begin : g_lvl
        assign w_lvl_mask[g] = lvl_mask(g);
        assign w_lvl_base[g] = lvl_base(g);
    end

    // ------------------------------------------------------------------
    // Stage 0: decode, shift the word index, issue table access
    // ------------------------------------------------------------------
    logic [WB-1:0]     r_wi;
    logic [SEEN_W-1:0] r_seen;
    logic [WB-1:0]     n_wi;
    logic [SEEN_W-1:0] n_seen;
    t_s1               r_s1;
    t_s1               n_s1;

    logic                   w_acc;
    logic [LEVEL_W-1:0]     w_k;
    logic [SYMBOL_BITS-1:0] w_sym;
    logic [WB-1:0]          w_wi_shift;
    logic                   w_short;
    logic [LEVEL_W-1:0]     w_rd_lvl;
    logic [JA-1:0]          w_joint_ra;
    logic [WB-1:0]          w_cond_wa;
    logic [JA-1:0]          w_joint_wa;
    logic                   w_cond_we;
    logic                   w_joint_we;
    logic                   w_cond_re;
    logic                   w_joint_re;

    assign w_acc      = i_req.valid && i_req.ready;
    assign w_k        = (r_order > LEVEL_W'(MAX_ORDER)) ? LEVEL_W'(MAX_ORDER) : r_order;
    assign w_sym      = SYMBOL_BITS'(i_req.symbol);
    assign w_wi_shift = ((r_wi << SYMBOL_BITS) | WB'(w_sym)) & w_lvl_mask[w_k];
    assign w_short    = int'(r_seen) < int'(w_k);

    // Short sequence reads the level of its length, a full word the level k
    assign w_rd_lvl   = w_short ? LEVEL_W'(r_seen) : w_k;
    assign w_joint_ra = w_lvl_base[w_rd_lvl] + JA'(w_wi_shift & w_lvl_mask[w_rd_lvl]);

    assign w_cond_wa  = WB'(i_req.table_index);
    assign w_joint_wa = w_lvl_base[i_req.table_level]
                      + JA'(WB'(i_req.table_index) & w_lvl_mask[i_req.table_level]);

    always_comb begin
        n_wi       = r_wi;
        n_seen     = r_seen;
        n_s1       = '{valid: 1'b0, kind: KIND_COND, last: 1'b0};
        w_cond_we  = 1'b0;
        w_joint_we = 1'b0;
        w_cond_re  = 1'b0;
        w_joint_re = 1'b0;
        if (w_acc) begin
            unique case (i_req.opcode)
                OP_LOAD_COND: begin
                    w_cond_we = 1'b1;
                end
                OP_LOAD_JOINT: begin
                    w_joint_we = (i_req.table_level <= LEVEL_W'(MAX_ORDER));
                end
                OP_SYMBOL: begin
                    n_wi = w_wi_shift;
                    if (w_short) begin
                        if (i_req.last_symbol) begin
                            w_joint_re = 1'b1;
                            n_s1       = '{valid: 1'b1, kind: KIND_SHORT, last: 1'b1};
                        end else begin
                            n_seen = r_seen + 1'b1;
                        end
                    end else begin
                        n_s1.valid = 1'b1;
                        n_s1.last  = i_req.last_symbol;
                        if (int'(r_seen) == int'(w_k)) begin
                            w_joint_re = 1'b1;
                            n_s1.kind  = KIND_JOINT;
                            n_seen     = r_seen + 1'b1;
                        end else begin
                            w_cond_re = 1'b1;
                            n_s1.kind = KIND_COND;
                        end
                    end
                    // Drop the sequence position at its end
                    if (i_req.last_symbol) begin
                        n_wi   = '0;
                        n_seen = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wi   <= '0;
            r_seen <= '0;
            r_s1   <= '0;
        end else begin
            r_wi   <= n_wi;
            r_seen <= n_seen;
            r_s1   <= n_s1;
        end
    end

    // ------------------------------------------------------------------
    // Table memories: one write and one registered read per cycle each.
    // A load and a symbol never share a cycle, so a read sees every earlier load.
    // ------------------------------------------------------------------
    logic [VALUE_W-1:0] m_cond  [COND_DEPTH];
    logic [VALUE_W-1:0] m_joint [JOINT_DEPTH];
    logic [VALUE_W-1:0] r_cond_q;
    logic [VALUE_W-1:0] r_joint_q;

    always_ff @(posedge i_clk) begin
        if (w_cond_we) begin
            m_cond[w_cond_wa] <= i_req.table_value;
        end
        if (w_cond_re) begin
            r_cond_q <= m_cond[w_wi_shift];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_joint_we) begin
            m_joint[w_joint_wa] <= i_req.table_value;
        end
        if (w_joint_re) begin
            r_joint_q <= m_joint[w_joint_ra];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: combine the entry into the running score
    // ------------------------------------------------------------------
    logic [SCORE_W-1:0] r_acc;
    logic               r_sat;
    logic               r_lin_pend;
    logic [PROD_W-1:0]  r_prod;
    logic [SCORE_W-1:0] n_acc;
    logic               n_sat;
    logic               n_lin_pend;
    logic               n_s2_valid;

    logic [VALUE_W-1:0] w_e;
    logic [SCORE_W-1:0] w_e_ext;
    logic [SCORE_W-1:0] w_eff;
    logic               w_eff_sat;
    logic [SCORE_W:0]   w_sum;
    logic               w_sum_ovf;
    logic [SCORE_W-1:0] w_sum_clamped;
    logic [PROD_W-1:0]  w_mult;
    logic               w_prod_load;
    logic [SCORE_W-1:0] w_res_val;
    logic               w_res_sat;
    logic               w_res_lin;

    assign w_e     = (r_s1.kind == KIND_COND) ? r_cond_q : r_joint_q;
    assign w_e_ext = r_log_mode ? {{EXT_W{w_e[VALUE_W-1]}}, w_e} : {{EXT_W{1'b0}}, w_e};

    // Running score with a pending linear product folded in
    assign w_eff     = r_lin_pend ? {{EXT_W{1'b0}}, prod_clamp(r_prod)} : r_acc;
    assign w_eff_sat = r_sat | (r_lin_pend & r_prod[PROD_W-1]);

    // Log mode: saturating 48-bit add
    assign w_sum         = {w_eff[SCORE_W-1], w_eff} + {{(EXT_W+1){w_e[VALUE_W-1]}}, w_e};
    assign w_sum_ovf     = w_sum[SCORE_W] ^ w_sum[SCORE_W-1];
    assign w_sum_clamped = w_sum_ovf ? (w_sum[SCORE_W] ? SCORE_MIN : SCORE_MAX)
                                     : w_sum[SCORE_W-1:0];

    // Linear mode: full product, registered, then renormalised and clamped
    assign w_mult      = PROD_W'(w_eff[VALUE_W-1:0]) * PROD_W'(w_e);
    assign w_prod_load = r_s1.valid && (r_s1.kind == KIND_COND) && !r_log_mode;

    always_comb begin
        n_acc      = r_acc;
        n_sat      = r_sat;
        n_lin_pend = r_lin_pend;
        n_s2_valid = 1'b0;
        w_res_val  = w_e_ext;
        w_res_sat  = 1'b0;
        w_res_lin  = 1'b0;
        if (r_s1.valid) begin
            unique case (r_s1.kind)
                KIND_SHORT: begin
                end
                KIND_JOINT: begin
                    n_acc      = w_e_ext;
                    n_sat      = 1'b0;
                    n_lin_pend = 1'b0;
                end
                KIND_COND: begin
                    if (r_log_mode) begin
                        w_res_val  = w_sum_clamped;
                        w_res_sat  = w_eff_sat | w_sum_ovf;
                        n_acc      = w_sum_clamped;
                        n_sat      = w_eff_sat | w_sum_ovf;
                        n_lin_pend = 1'b0;
                    end else begin
                        w_res_val  = w_eff;
                        w_res_sat  = w_eff_sat;
                        w_res_lin  = 1'b1;
                        n_sat      = w_eff_sat;
                        n_lin_pend = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            // Clear the running score behind the final symbol
            if (r_s1.last) begin
                n_acc      = '0;
                n_sat      = 1'b0;
                n_lin_pend = 1'b0;
                n_s2_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_sat      <= 1'b0;
            r_lin_pend <= 1'b0;
        end else begin
            r_acc      <= n_acc;
            r_sat      <= n_sat;
            r_lin_pend <= n_lin_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_prod_load) begin
            r_prod <= w_mult;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: finish the result word and queue it
    // ------------------------------------------------------------------
    logic               r_s2_valid;
    logic               r_s2_lin;
    logic               r_s2_sat;
    logic [SCORE_W-1:0] r_s2_val;
    logic [PROD_W-1:0]  r_s2_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= n_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_s2_valid) begin
            r_s2_lin  <= w_res_lin;
            r_s2_sat  <= w_res_sat;
            r_s2_val  <= w_res_val;
            r_s2_prod <= w_mult;
        end
    end

    t_result    w_push_data;
    t_result    w_head;
    t_fifo_stat w_fifo_stat;
    logic       w_pop;

    assign w_push_data.score = r_s2_lin ? {{EXT_W{1'b0}}, prod_clamp(r_s2_prod)} : r_s2_val;
    assign w_push_data.score_saturated = r_s2_sat | (r_s2_lin & r_s2_prod[PROD_W-1]);

    msc_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_s2_valid),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_stat      (w_fifo_stat)
    );

    // Take a word only while the FIFO has room for every result in flight
    logic [OUT_CNT_W-1:0] w_inflight;

    assign w_inflight  = w_fifo_stat.count
                       + OUT_CNT_W'(r_s1.valid & r_s1.last)
                       + OUT_CNT_W'(r_s2_valid);
    assign i_req.ready = (w_inflight < OUT_CNT_W'(OUT_DEPTH));

    assign o_rsp.valid           = w_fifo_stat.not_empty;
    assign o_rsp.score           = w_head.score;
    assign o_rsp.score_saturated = w_head.score_saturated;
    assign w_pop                 = o_rsp.valid && o_rsp.ready;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `MSC_ASSERT_NEXT(a_last_reaches_queue, i_clk, i_rst_n, r_s1.valid && r_s1.last, r_s2_valid)
    `MSC_ASSERT_IMPL(a_queue_has_room, i_clk, i_rst_n, r_s2_valid, !w_fifo_stat.full)
    `MSC_ASSERT_NEXT(a_score_cleared_after_last, i_clk, i_rst_n, r_s1.valid && r_s1.last, (r_acc == '0) && !r_sat && !r_lin_pend)

endmodule
